/* sv/rotenc_pkg.sv */
package rotenc_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// register reset values
	localparam logic [7:0]  SHORT_LIM_RST  = 8'd1;
	localparam logic [7:0]  LONG_LIM_RST   = 8'd1;
	localparam logic [7:0]  DEB_LIM_RST    = 8'd7;
	localparam logic [15:0] LONG_PRESS_RST = 16'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POS_LOW    = 3'd0,
		REG_POS_HIGH   = 3'd1,
		REG_POS_START  = 3'd2,
		REG_SHORT_LIM  = 3'd3,
		REG_LONG_LIM   = 3'd4,
		REG_DEB_LIM    = 3'd5,
		REG_LONG_PRESS = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] pos_low;
		logic signed [15:0] pos_high;
		logic [7:0]         short_lim;
		logic [7:0]         long_lim;
		logic [7:0]         deb_lim;
		logic [15:0]        long_press_lim;
	} cfg_t;

	typedef struct packed {
		logic               load;
		logic signed [15:0] value;
	} pos_load_t;

	typedef struct packed {
		logic pin_a;
		logic pin_b;
		logic button;
	} pins_t;

	typedef struct packed {
		logic signed [15:0] position;
		logic [7:0]         short_count;
		logic [7:0]         long_count;
	} result_t;

	// wraps to zero once the limit is reached
	function automatic logic [7:0] cycle_count(input logic [7:0] c, input logic [7:0] lim);
		return (c < lim) ? c + 8'd1 : 8'd0;
	endfunction

endpackage

/* sv/rotenc_cfg.sv */
module rotenc_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 we,
	input  logic [rotenc_pkg::CFG_IDX_W-1:0]     index,
	input  logic [rotenc_pkg::CFG_DATA_W-1:0]    data,
	output rotenc_pkg::cfg_t                     cfg,
	output rotenc_pkg::pos_load_t                pos_load
);
	import rotenc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_low        <= '0;
			cfg_q.pos_high       <= '0;
			cfg_q.short_lim      <= SHORT_LIM_RST;
			cfg_q.long_lim       <= LONG_LIM_RST;
			cfg_q.deb_lim        <= DEB_LIM_RST;
			cfg_q.long_press_lim <= LONG_PRESS_RST;
		end else if (we) begin
			case (reg_idx_t'(index))
				REG_POS_LOW:    cfg_q.pos_low        <= $signed(data);
				REG_POS_HIGH:   cfg_q.pos_high       <= $signed(data);
				REG_SHORT_LIM:  cfg_q.short_lim      <= data[7:0];
				REG_LONG_LIM:   cfg_q.long_lim       <= data[7:0];
				REG_DEB_LIM:    cfg_q.deb_lim        <= data[7:0];
				REG_LONG_PRESS: cfg_q.long_press_lim <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// start value goes straight into the position counter
	assign pos_load.load  = we && (reg_idx_t'(index) == REG_POS_START);
	assign pos_load.value = $signed(data);

endmodule

/* sv/rotenc_core.sv */
module rotenc_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  rotenc_pkg::pins_t     pins,
	input  rotenc_pkg::cfg_t      cfg,
	input  rotenc_pkg::pos_load_t pos_load,
	output rotenc_pkg::result_t   nxt
);
	import rotenc_pkg::*;

	logic [7:0]         rot_q;
	logic [15:0]        btn_q;
	logic               press_q;
	logic               long_q;
	logic signed [15:0] pos_q;
	logic [7:0]         sc_q;
	logic [7:0]         lc_q;

	logic [7:0]         rot_n;
	logic [15:0]        btn_n;
	logic               press_n;
	logic               long_n;
	logic signed [15:0] pos_n;
	logic [7:0]         sc_n;
	logic [7:0]         lc_n;
	logic               rot_hit;
	logic               long_hit;
	logic               short_hit;

	// rotation integrator
	always_comb begin
		rot_n = rot_q;
		if (!pins.pin_a && (rot_q < cfg.deb_lim))
			rot_n = rot_q + 8'd1;
		else if (rot_q != 8'd0)
			rot_n = rot_q - 8'd1;
	end

	// button integrator, release clamps to the debounce ceiling first
	always_comb begin
		btn_n = btn_q;
		if (!pins.button && (btn_q < cfg.long_press_lim))
			btn_n = btn_q + 16'd1;
		else if (btn_q != 16'd0) begin
			if (btn_q > {8'd0, cfg.deb_lim})
				btn_n = {8'd0, cfg.deb_lim};
			else
				btn_n = btn_q - 16'd1;
		end
	end

	// x > lim - 2 written as x + 2 > lim, one bit wider
	assign rot_hit   = ({1'b0, rot_n} + 9'd2) > {1'b0, cfg.deb_lim};
	assign long_hit  = ({1'b0, btn_n} + 17'd2) > {1'b0, cfg.long_press_lim};
	assign short_hit = ({1'b0, btn_n} + 17'd2) > {9'd0, cfg.deb_lim};

	always_comb begin
		press_n = press_q;
		long_n  = long_q;
		pos_n   = pos_q;
		sc_n    = sc_q;
		lc_n    = lc_q;
		if (rot_hit && !press_n) begin
			press_n = 1'b1;
			if (!pins.pin_b && (pos_q < cfg.pos_high))
				pos_n = pos_q + 16'sd1;
			else if (pins.pin_b && (pos_q > cfg.pos_low))
				pos_n = pos_q - 16'sd1;
		end
		if ((rot_n == 8'd0) && (btn_n == 16'd0)) begin
			press_n = 1'b0;
			long_n  = 1'b0;
		end
		if (long_hit && !long_n) begin
			long_n = 1'b1;
			lc_n   = cycle_count(lc_q, cfg.long_lim);
			sc_n   = 8'd0;
		end
		if (short_hit && !press_n) begin
			press_n = 1'b1;
			sc_n    = cycle_count(sc_n, cfg.short_lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q   <= '0;
			btn_q   <= '0;
			press_q <= 1'b0;
			long_q  <= 1'b0;
			sc_q    <= '0;
			lc_q    <= '0;
		end else if (step) begin
			rot_q   <= rot_n;
			btn_q   <= btn_n;
			press_q <= press_n;
			long_q  <= long_n;
			sc_q    <= sc_n;
			lc_q    <= lc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (pos_load.load)
			pos_q <= pos_load.value;
		else if (step)
			pos_q <= pos_n;
	end

	assign nxt.position    = pos_n;
	assign nxt.short_count = sc_n;
	assign nxt.long_count  = lc_n;

endmodule

/* sv/rotary_encoder_button_debouncer.sv */
// pipeline: an accepted item is registered in stage 1, and its state update and result
// are registered in stage 2 when the result register is free or being emptied
// throughput: one item per cycle while the output is not stalled; the state update is a
// single short pass between the stage-1 input register and the stage-2 result register
// reset: asynchronous, active low; integrators, latches and counters clear,
// position goes to zero and the registers return to their defaults
module rotary_encoder_button_debouncer (
	input  logic                              clk,
	input  logic                              arst_n,
	// tick input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              pin_a_level,
	input  logic                              pin_b_level,
	input  logic                              button_level,
	// result output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [15:0]                position,
	output logic [7:0]                        short_count,
	output logic [7:0]                        long_count,
	// register writes
	input  logic                              cfg_we,
	input  logic [rotenc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rotenc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rotenc_pkg::*;

	cfg_t      cfg;
	pos_load_t pos_load;
	result_t   nxt;

	logic    valid_s1;
	pins_t   pins_s1;
	logic    valid_s2;
	result_t result_s2;
	logic    advance;

	// register file, also raises the position load strobe
	rotenc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (cfg_we),
		.index    (cfg_index),
		.data     (cfg_data),
		.cfg      (cfg),
		.pos_load (pos_load)
	);

	// the stage-1 item moves on when the result register is free or being emptied;
	// the state commits in the same cycle so the next item sees it at once
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// stage 1: accepted pin levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pins_s1.pin_a  <= pin_a_level;
			pins_s1.pin_b  <= pin_b_level;
			pins_s1.button <= button_level;
		end
	end

	// integrators, latches, position and press counters
	rotenc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.pins     (pins_s1),
		.cfg      (cfg),
		.pos_load (pos_load),
		.nxt      (nxt)
	);

	// stage 2: result held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (out_ready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= nxt;
	end

	assign out_valid   = valid_s2;
	assign position    = result_s2.position;
	assign short_count = result_s2.short_count;
	assign long_count  = result_s2.long_count;

	// a stalled stage-1 item must stay put
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !out_ready) |=> (valid_s1 && $stable(pins_s1)))
		else $error("stage-1 item lost or changed during output stall");

	// every committed state update must produce a result
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("state update without a result");

	// an accepted item must land in stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted item not captured");

endmodule
